/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vsp_pkg.sv */
// ----------------------------------------------------------------------------
// vsp_pkg
// Widths, register indexes and stage payload types of the pixel budget scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsp_pkg;

    localparam int DIM_W    = 14;
    localparam int BUDGET_W = 24;
    localparam int AREA_W   = 28;
    localparam int PROD_W   = 38;
    localparam int SHIFT_W  = 3;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0] REG_WIDTH_LIMIT  = 1'b0;
    localparam logic [IDX_W-1:0] REG_HEIGHT_LIMIT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_LIMIT_RST  = 14'd4096;
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT_RST = 14'd3072;

    // Original size and budget, carried to the end of the pipe
    typedef struct packed {
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [BUDGET_W-1:0] budget;
        logic [AREA_W-1:0]   area;
        logic                zero;
    } src_t;

    // Sideband through the width clamp divider
    typedef struct packed {
        src_t src;
        logic cut;
    } s1_t;

    // Sideband through the height clamp divider
    typedef struct packed {
        src_t             src;
        logic [DIM_W-1:0] nw;
        logic [DIM_W-1:0] nh;
        logic             cut;
    } s2_t;

    // Sideband through the budget divider and square root
    typedef struct packed {
        src_t             src;
        logic [DIM_W-1:0] nw;
        logic [DIM_W-1:0] nh;
        logic             cut;
    } s4_t;

    // Sideband through the final height divider
    typedef struct packed {
        s4_t              s4;
        logic [DIM_W-1:0] root;
    } s5_t;

endpackage

/* rtl/vsp_if.sv */
// ----------------------------------------------------------------------------
// vsp_req_if / vsp_rsp_if
// Valid/ready channels carrying size requests and scaled size results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vsp_req_if;
    import vsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_W-1:0]    source_width;
    logic [DIM_W-1:0]    source_height;
    logic [BUDGET_W-1:0] pixel_budget;

    modport source (output valid, output source_width, output source_height,
                    output pixel_budget, input ready);
    modport sink   (input valid, input source_width, input source_height,
                    input pixel_budget, output ready);
endinterface

interface vsp_rsp_if;
    import vsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIM_W-1:0]   result_width;
    logic [DIM_W-1:0]   result_height;
    logic [SHIFT_W-1:0] scale_shift;
    logic               zero_target;

    modport source (output valid, output result_width, output result_height,
                    output scale_shift, output zero_target, input ready);
    modport sink   (input valid, input result_width, input result_height,
                    input scale_shift, input zero_target, output ready);
endinterface

/* rtl/vsp_div_pipe.sv */
// ----------------------------------------------------------------------------
// vsp_div_pipe
// Restoring divider, one quotient bit per register stage, with sideband.
// The quotient must fit in Q_W bits; otherwise the result is meaningless.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsp_div_pipe #(
    parameter int NUM_W  = 28,
    parameter int DEN_W  = 14,
    parameter int Q_W    = 14,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] side_out
);

    localparam int EXT_W = NUM_W + DEN_W;

    logic [EXT_W-1:0]  num_ext;
    logic              vld_reg  [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    assign num_ext = EXT_W'(num);

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [Q_W-1:0]    low_in;
        logic [Q_W-1:0]    q_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in_s;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        // Select the previous stage, or the inputs for the first one
        if (i == 0) begin : g_first
            assign vld_in    = in_valid;
            assign rem_in    = num_ext[Q_W +: DEN_W];
            assign low_in    = num[Q_W-1:0];
            assign q_in      = '0;
            assign den_in    = den;
            assign side_in_s = side_in;
        end else begin : g_next
            assign vld_in    = vld_reg[i-1];
            assign rem_in    = rem_reg[i-1];
            assign low_in    = low_reg[i-1];
            assign q_in      = q_reg[i-1];
            assign den_in    = den_reg[i-1];
            assign side_in_s = side_reg[i-1];
        end

        // Shift in one numerator bit and try a subtract
        always_comb
        begin
            trial = {rem_in, low_in[Q_W-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[i]  <= low_in << 1;
                q_reg[i]    <= {q_in[Q_W-2:0], ge};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in_s;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

/* rtl/vsp_isqrt_pipe.sv */
// ----------------------------------------------------------------------------
// vsp_isqrt_pipe
// Integer square root, one root bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsp_isqrt_pipe #(
    parameter int R_W    = 14,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*R_W-1:0]  radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [R_W-1:0]    root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int X_W   = 2 * R_W;
    localparam int REM_W = R_W + 3;

    logic              vld_reg  [R_W];
    logic [REM_W-1:0]  rem_reg  [R_W];
    logic [X_W-1:0]    x_reg    [R_W];
    logic [R_W-1:0]    root_reg [R_W];
    logic [SIDE_W-1:0] side_reg [R_W];

    for (genvar i = 0; i < R_W; i++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [X_W-1:0]    x_in;
        logic [R_W-1:0]    root_in;
        logic [SIDE_W-1:0] side_in_s;
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign vld_in    = in_valid;
            assign rem_in    = '0;
            assign x_in      = radicand;
            assign root_in   = '0;
            assign side_in_s = side_in;
        end else begin : g_next
            assign vld_in    = vld_reg[i-1];
            assign rem_in    = rem_reg[i-1];
            assign x_in      = x_reg[i-1];
            assign root_in   = root_reg[i-1];
            assign side_in_s = side_reg[i-1];
        end

        // Bring down two radicand bits and test root*4+1
        always_comb
        begin
            cand  = {rem_in[REM_W-3:0], x_in[X_W-1:X_W-2]};
            trial = REM_W'({root_in, 2'b01});
            ge    = (cand >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (cand - trial) : cand;
                x_reg[i]    <= x_in << 2;
                root_reg[i] <= {root_in[R_W-2:0], ge};
                side_reg[i] <= side_in_s;
            end
        end
    end

    assign out_valid = vld_reg[R_W-1];
    assign root      = root_reg[R_W-1];
    assign side_out  = side_reg[R_W-1];

endmodule

/* rtl/video_scale_to_pixel_budget_core.sv */
// Pixel budget frame scaler. Each request (width, height, pixel budget) is
// clamped to the width and height limits, fitted to the budget by square
// root, and answered with the power-of-two downscale of the original size
// whose area comes closest to that target without exceeding it (the largest
// shift if none fits). The block takes one request per clock; the bit-serial
// dividers and the square root produce one result bit per register stage.
// A stall at the result side freezes the whole pipe. Limits may only be
// changed while the pipe is empty.
// ----------------------------------------------------------------------------
// video_scale_to_pixel_budget_core
// Top level of the pipelined pixel budget scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module video_scale_to_pixel_budget_core #(
    parameter int SCALE_STEPS = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [vsp_pkg::IDX_W-1:0] cfg_index,
    input  logic [vsp_pkg::DIM_W-1:0] cfg_data,
    vsp_req_if.sink                   req,
    vsp_rsp_if.source                 rsp
);
    import vsp_pkg::*;

    logic               adv;
    logic [DIM_W-1:0]   wl_reg;
    logic [DIM_W-1:0]   hl_reg;

    logic               a_vld_reg;
    logic [DIM_W-1:0]   a_w_reg;
    logic [DIM_W-1:0]   a_h_reg;
    logic [BUDGET_W-1:0] a_b_reg;

    logic               b_vld_reg;
    s1_t                b_side_reg;
    logic [AREA_W-1:0]  b_p1_reg;

    logic               d1_vld;
    logic [DIM_W-1:0]   d1_q;
    logic [$bits(s1_t)-1:0] d1_side_raw;
    s1_t                d1_side;

    logic               c_vld_reg;
    s2_t                c_side_reg;
    s2_t                c_side_next;
    logic [AREA_W-1:0]  c_p2_reg;

    logic               d2_vld;
    logic [DIM_W-1:0]   d2_q;
    logic [$bits(s2_t)-1:0] d2_side_raw;
    s2_t                d2_side;

    logic               d_vld_reg;
    s4_t                d_side_reg;
    s4_t                d_side_next;
    logic [AREA_W-1:0]  d_prod_reg;

    logic               e_vld_reg;
    s4_t                e_side_reg;
    s4_t                e_side_next;
    logic [PROD_W-1:0]  e_pb_reg;

    logic               d3_vld;
    logic [AREA_W-1:0]  d3_q;
    logic [$bits(s4_t)-1:0] d3_side;

    logic               sq_vld;
    logic [DIM_W-1:0]   sq_root;
    logic [$bits(s4_t)-1:0] sq_side_raw;
    s5_t                sq_side;

    logic               d4_vld;
    logic [BUDGET_W-1:0] d4_q;
    logic [$bits(s5_t)-1:0] d4_side_raw;
    s5_t                d4_side;

    logic               f_vld_reg;
    src_t               f_src_reg;
    logic [DIM_W-1:0]   f_w_reg;
    logic [BUDGET_W-1:0] f_h_reg;

    logic               g_vld_reg;
    src_t               g_src_reg;
    logic [PROD_W-1:0]  g_target_reg;

    logic               o_vld_reg;
    logic [DIM_W-1:0]   o_w_reg;
    logic [DIM_W-1:0]   o_h_reg;
    logic [SHIFT_W-1:0] o_k_reg;
    logic               o_zero_reg;
    logic [SHIFT_W-1:0] best;
    logic               zt;

    // Round a side to nearest (half up) after dividing by 2^k
    function automatic logic [DIM_W-1:0] round_shift(input logic [DIM_W-1:0] v,
                                                      input logic [SHIFT_W-1:0] k);
        logic [DIM_W+1:0] sum;
        logic [DIM_W+1:0] shifted;
        sum     = {1'b0, v, 1'b0} + ((DIM_W+2)'(1) << k);
        shifted = sum >> ({1'b0, k} + 4'd1);
        return shifted[DIM_W-1:0];
    endfunction

    // Whole pipe advances unless a finished result is held
    assign adv       = !o_vld_reg || rsp.ready;
    assign req.ready = adv;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WIDTH_LIMIT_RST;
            hl_reg <= HEIGHT_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_WIDTH_LIMIT:  wl_reg <= cfg_data;
                REG_HEIGHT_LIMIT: hl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits of the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= req.valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= d1_vld;
            d_vld_reg <= d2_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= d4_vld;
            g_vld_reg <= f_vld_reg;
            o_vld_reg <= g_vld_reg;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_w_reg <= req.source_width;
            a_h_reg <= req.source_height;
            a_b_reg <= req.pixel_budget;
        end
    end

    // Form the original area and the width clamp product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg.src.w      <= a_w_reg;
            b_side_reg.src.h      <= a_h_reg;
            b_side_reg.src.budget <= a_b_reg;
            b_side_reg.src.area   <= AREA_W'(a_w_reg) * AREA_W'(a_h_reg);
            b_side_reg.src.zero   <= (a_w_reg == '0) || (a_h_reg == '0);
            b_side_reg.cut        <= (a_w_reg > wl_reg);
            b_p1_reg              <= AREA_W'(a_h_reg) * AREA_W'(wl_reg);
        end
    end

    // Height scaled by the width clamp
    vsp_div_pipe #(
        .NUM_W (AREA_W),
        .DEN_W (DIM_W),
        .Q_W   (DIM_W),
        .SIDE_W($bits(s1_t))
    ) u_div_wclamp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (b_vld_reg),
        .num      (b_p1_reg),
        .den      (b_side_reg.src.w),
        .side_in  (b_side_reg),
        .out_valid(d1_vld),
        .quot     (d1_q),
        .side_out (d1_side_raw)
    );
    assign d1_side = s1_t'(d1_side_raw);

    // Apply the width clamp, prepare the height clamp product
    always_comb
    begin
        c_side_next.src = d1_side.src;
        c_side_next.nw  = d1_side.cut ? wl_reg : d1_side.src.w;
        c_side_next.nh  = d1_side.cut ? d1_q : d1_side.src.h;
        c_side_next.cut = (c_side_next.nh > hl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= c_side_next;
            c_p2_reg   <= AREA_W'(c_side_next.nw) * AREA_W'(hl_reg);
        end
    end

    // Width scaled by the height clamp
    vsp_div_pipe #(
        .NUM_W (AREA_W),
        .DEN_W (DIM_W),
        .Q_W   (DIM_W),
        .SIDE_W($bits(s2_t))
    ) u_div_hclamp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (c_vld_reg),
        .num      (c_p2_reg),
        .den      (c_side_reg.nh),
        .side_in  (c_side_reg),
        .out_valid(d2_vld),
        .quot     (d2_q),
        .side_out (d2_side_raw)
    );
    assign d2_side = s2_t'(d2_side_raw);

    // Apply the height clamp and form the clamped area
    always_comb
    begin
        d_side_next.src = d2_side.src;
        d_side_next.nw  = d2_side.cut ? d2_q : d2_side.nw;
        d_side_next.nh  = d2_side.cut ? hl_reg : d2_side.nh;
        d_side_next.cut = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg <= d_side_next;
            d_prod_reg <= AREA_W'(d_side_next.nw) * AREA_W'(d_side_next.nh);
        end
    end

    // Compare against the budget, form budget times width
    always_comb
    begin
        e_side_next     = d_side_reg;
        e_side_next.cut = (d_prod_reg > AREA_W'(d_side_reg.src.budget));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_side_reg <= e_side_next;
            e_pb_reg   <= PROD_W'(d_side_reg.src.budget) * PROD_W'(d_side_reg.nw);
        end
    end

    // budget * w / h; below w*w when the budget cut applies
    vsp_div_pipe #(
        .NUM_W (PROD_W),
        .DEN_W (DIM_W),
        .Q_W   (AREA_W),
        .SIDE_W($bits(s4_t))
    ) u_div_budget (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (e_vld_reg),
        .num      (e_pb_reg),
        .den      (e_side_reg.nh),
        .side_in  (e_side_reg),
        .out_valid(d3_vld),
        .quot     (d3_q),
        .side_out (d3_side)
    );

    vsp_isqrt_pipe #(
        .R_W   (DIM_W),
        .SIDE_W($bits(s4_t))
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (d3_vld),
        .radicand (d3_q),
        .side_in  (d3_side),
        .out_valid(sq_vld),
        .root     (sq_root),
        .side_out (sq_side_raw)
    );

    always_comb
    begin
        sq_side.s4   = s4_t'(sq_side_raw);
        sq_side.root = sq_root;
    end

    // Height from the budget and the new width
    vsp_div_pipe #(
        .NUM_W (BUDGET_W),
        .DEN_W (DIM_W),
        .Q_W   (BUDGET_W),
        .SIDE_W($bits(s5_t))
    ) u_div_height (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (sq_vld),
        .num      (sq_side.s4.src.budget),
        .den      (sq_root),
        .side_in  (sq_side),
        .out_valid(d4_vld),
        .quot     (d4_q),
        .side_out (d4_side_raw)
    );
    assign d4_side = s5_t'(d4_side_raw);

    // Pick the target sides
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_src_reg <= d4_side.s4.src;
            if (d4_side.s4.cut)
            begin
                f_w_reg <= d4_side.root;
                f_h_reg <= (d4_side.root == '0) ? '0 : d4_q;
            end
            else
            begin
                f_w_reg <= d4_side.s4.nw;
                f_h_reg <= BUDGET_W'(d4_side.s4.nh);
            end
        end
    end

    // Target area
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_src_reg    <= f_src_reg;
            g_target_reg <= PROD_W'(f_w_reg) * PROD_W'(f_h_reg);
        end
    end

    // Smallest shift whose area does not exceed the target, else the largest
    always_comb
    begin
        best = SHIFT_W'(SCALE_STEPS - 1);
        for (int k = SCALE_STEPS - 1; k >= 0; k--)
        begin
            if (g_target_reg >= PROD_W'(g_src_reg.area >> (2 * k)))
            begin
                best = SHIFT_W'(k);
            end
        end
        zt = g_src_reg.zero || (g_target_reg == '0);
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_zero_reg <= zt;
            o_k_reg    <= zt ? '0 : best;
            o_w_reg    <= zt ? '0 : round_shift(g_src_reg.w, best);
            o_h_reg    <= zt ? '0 : round_shift(g_src_reg.h, best);
        end
    end

    assign rsp.valid         = o_vld_reg;
    assign rsp.result_width  = o_w_reg;
    assign rsp.result_height = o_h_reg;
    assign rsp.scale_shift   = o_k_reg;
    assign rsp.zero_target   = o_zero_reg;

    // A flagged result carries zero sides and zero shift
    `ASSERT_SAME(a_zero_clears, clk, rst_n, o_vld_reg && o_zero_reg,
        (o_w_reg == '0) && (o_h_reg == '0) && (o_k_reg == '0),
        "zero target result with nonzero fields")
    // The chosen shift stays within the configured steps
    `ASSERT_SAME(a_shift_range, clk, rst_n, o_vld_reg,
        o_k_reg <= SHIFT_W'(SCALE_STEPS - 1), "scale shift out of range")
    // A held result keeps the whole pipe frozen
    `ASSERT_NEXT(a_hold_freezes, clk, rst_n, o_vld_reg && !rsp.ready && g_vld_reg,
        o_vld_reg && g_vld_reg, "pipe advanced while result held")

endmodule
